FILE: rtl/dsvu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvu_pkg: shared types, constants and helpers
// Beat formats, queue entry, widths of the length and divider datapaths.
// ----------------------------------------------------------------------------
package dsvu_pkg;

  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int SQRT_STAGES = 32;
  localparam int DIV_QW      = 47;
  localparam int DIV_NUM_W   = 63;
  localparam int LEN_W       = 32;

  localparam logic [16:0] TIME_STEP_RESET = 17'd1049;

  typedef struct packed {
    logic signed [31:0] pos_diff_x;
    logic signed [31:0] pos_diff_y;
    logic signed [31:0] pos_diff_z;
    logic signed [31:0] vel_diff_x;
    logic signed [31:0] vel_diff_y;
    logic signed [31:0] vel_diff_z;
    logic [30:0]        rest_length;
    logic [30:0]        stiffness;
    logic [30:0]        damping;
    logic [30:0]        inv_mass_a;
    logic [30:0]        inv_mass_b;
    logic               pinned;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] dvel_a_x;
    logic signed [31:0] dvel_a_y;
    logic signed [31:0] dvel_a_z;
    logic signed [31:0] dvel_b_x;
    logic signed [31:0] dvel_b_y;
    logic signed [31:0] dvel_b_z;
  } out_item_t;

  typedef enum logic {
    KIND_ACTIVE,
    KIND_PINNED
  } kind_t;

  typedef struct packed {
    kind_t    kind;
    in_item_t item;
  } q_entry_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic valid;
  } q_status_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Shift right by 16, rounding toward zero
  function automatic logic [47:0] trunc16(input logic [63:0] p);
    logic [63:0] m;
    logic [47:0] t;
    m = p[63] ? (64'd0 - p) : p;
    t = m[63:16];
    return p[63] ? (48'd0 - t) : t;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Apply sign to a magnitude and saturate to 32 bits
  function automatic logic [31:0] sat_mag(input logic neg, input logic [46:0] m);
    logic [31:0] r;
    if (neg) begin
      r = (m > 47'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end else begin
      r = (m > 47'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/damped_spring_velocity_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_velocity_update: damped spring velocity change, one per beat
//
// Input channel (in_valid / in_stall / in_data) carries one spring per beat:
// end-to-end position and velocity differences, rest length, stiffness,
// damping, both inverse masses and a pinned flag. The result channel
// (out_valid / out_stall / out_data) returns one beat per input beat with
// the velocity changes of both ends, in order.
// cfg_we / cfg_wdata write the time step; write it only while idle.
// Throughput: one beat per cycle, sustained, while the receiver does not stall.
// Each beat passes through the 32-stage square root and two 48-stage
// dividers in series.
// Reset clears the queue and all pipeline valid bits and loads the time
// step with 1049 (about 0.016 s).
// When the receiver stalls, the result holds and the whole datapath
// freezes; the input queue keeps taking beats until its four entries fill,
// then in_stall rises.
// ----------------------------------------------------------------------------
module damped_spring_velocity_update (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dsvu_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dsvu_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [16:0]          cfg_wdata
);
  import dsvu_pkg::*;

  logic [16:0] time_step_r, time_step_nxt;
  q_status_t   q_status;
  q_entry_t    q_head;
  logic        pop;

  // Time step register, loaded on every write beat
  assign time_step_nxt = cfg_we ? cfg_wdata : time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RESET;
    end else begin
      time_step_r <= time_step_nxt;
    end
  end

  // Front: accept beats, tag pinned springs, queue them
  dsvu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .pop      (pop),
    .q_status (q_status),
    .q_head   (q_head)
  );

  // Back: length, force and velocity change pipeline with output register
  dsvu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_head    (q_head),
    .pop       (pop),
    .time_step (time_step_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/dsvu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvu_front: input acceptance and classification
// Takes beats, tags pinned springs and holds them in a short queue.
// ----------------------------------------------------------------------------
module dsvu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dsvu_pkg::in_item_t in_data,
  input  logic               pop,
  output dsvu_pkg::q_status_t q_status,
  output dsvu_pkg::q_entry_t q_head
);
  import dsvu_pkg::*;

  q_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               push, pop_ok;
  q_entry_t           entry;

  assign in_stall = (count_r == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop_ok   = pop && (count_r != '0);

  always_comb begin
    entry.item = in_data;
    entry.kind = in_data.pinned ? KIND_PINNED : KIND_ACTIVE;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  assign q_status.valid = (count_r != '0);
  assign q_head         = mem_r[rd_ptr_r];

endmodule

FILE: rtl/dsvu_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvu_sqrt: pipelined integer square root
// One result bit per stage, floor of the root of a 64-bit value.
// ----------------------------------------------------------------------------
module dsvu_sqrt (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       s,
  output logic [dsvu_pkg::LEN_W-1:0] root
);
  import dsvu_pkg::*;

  logic [35:0]      rem_r  [SQRT_STAGES];
  logic [LEN_W-1:0] root_r [SQRT_STAGES];
  logic [63:0]      s_r    [SQRT_STAGES];

  genvar j;
  generate
    for (j = 0; j < SQRT_STAGES; j++) begin : g_stage
      logic [35:0]      rem_i;
      logic [LEN_W-1:0] root_i;
      logic [63:0]      s_i;
      logic [35:0]      r2, trial;
      logic             ge;

      if (j == 0) begin : g_first
        assign rem_i  = '0;
        assign root_i = '0;
        assign s_i    = s;
      end else begin : g_next
        assign rem_i  = rem_r[j-1];
        assign root_i = root_r[j-1];
        assign s_i    = s_r[j-1];
      end

      always_comb begin
        r2    = {rem_i[33:0], s_i[63:62]};
        trial = {2'b00, root_i, 2'b01};
        ge    = (r2 >= trial);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j]  <= ge ? (r2 - trial) : r2;
          root_r[j] <= {root_i[LEN_W-2:0], ge};
          s_r[j]    <= {s_i[61:0], 2'b00};
        end
      end
    end
  endgenerate

  assign root = root_r[SQRT_STAGES-1];

endmodule

FILE: rtl/dsvu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvu_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module dsvu_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dsvu_pkg::DIV_NUM_W-1:0] num,
  input  logic [dsvu_pkg::LEN_W-1:0]     den,
  output logic [dsvu_pkg::DIV_QW-1:0]    quo,
  output logic                          ovf
);
  import dsvu_pkg::*;

  logic [LEN_W-1:0]  rem_r [DIV_QW+1];
  logic [LEN_W-1:0]  den_r [DIV_QW+1];
  logic [DIV_QW-1:0] n_r   [DIV_QW+1];
  logic [DIV_QW-1:0] q_r   [DIV_QW+1];
  logic              ovf_r [DIV_QW+1];

  // Head stage: quotient at or beyond 2^DIV_QW flags overflow
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= LEN_W'(num[DIV_NUM_W-1:DIV_QW]);
      den_r[0] <= den;
      n_r[0]   <= num[DIV_QW-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (LEN_W'(num[DIV_NUM_W-1:DIV_QW]) >= den);
    end
  end

  genvar j;
  generate
    for (j = 1; j <= DIV_QW; j++) begin : g_stage
      logic [LEN_W:0] r2;
      logic           ge;

      always_comb begin
        r2 = {rem_r[j-1], n_r[j-1][DIV_QW-1]};
        ge = (r2 >= {1'b0, den_r[j-1]});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? LEN_W'(r2 - {1'b0, den_r[j-1]}) : r2[LEN_W-1:0];
          den_r[j] <= den_r[j-1];
          n_r[j]   <= {n_r[j-1][DIV_QW-2:0], 1'b0};
          q_r[j]   <= {q_r[j-1][DIV_QW-2:0], ge};
          ovf_r[j] <= ovf_r[j-1];
        end
      end
    end
  endgenerate

  assign quo = q_r[DIV_QW];
  assign ovf = ovf_r[DIV_QW];

endmodule

FILE: rtl/dsvu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvu_back: spring force and velocity change datapath
// Length, Hooke and damping force, projection and mass scaling.
// ----------------------------------------------------------------------------
module dsvu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsvu_pkg::q_status_t  q_status,
  input  dsvu_pkg::q_entry_t   q_head,
  output logic                 pop,
  input  logic [16:0]          time_step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dsvu_pkg::out_item_t  out_data
);
  import dsvu_pkg::*;

  typedef struct packed {
    logic               v;
    kind_t              kind;
    in_item_t           item;
    logic signed [31:0] dot;
  } sq_side_t;

  typedef struct packed {
    logic               v;
    kind_t              kind;
    in_item_t           item;
    logic [LEN_W-1:0]   len;
    logic [47:0]        hooke;
    logic               dneg;
  } d1_side_t;

  typedef struct packed {
    logic        v;
    kind_t       kind;
    logic [30:0] ima;
    logic [30:0] imb;
  } d2_side_t;

  logic en;

  // s1: popped beat
  logic     s1_v_r;
  q_entry_t s1_r;
  // s2: squares and velocity products
  logic               s2_v_r;
  q_entry_t           s2_r;
  logic [63:0]        s2_sq_r [3];
  logic signed [63:0] s2_pr_r [3];
  // s3: sum of squares, dot product
  sq_side_t    s3_r;
  logic [63:0] s3_sum_r;
  // s4: length, extension, damping numerator
  logic               s4_v_r;
  kind_t              s4_kind_r;
  in_item_t           s4_item_r;
  logic [LEN_W-1:0]   s4_len_r;
  logic signed [31:0] s4_ext_r;
  logic [62:0]        s4_dm_r;
  logic               s4_dneg_r;
  // s5 / s6 / s7
  d1_side_t           s5_r;
  logic               s6_v_r;
  kind_t              s6_kind_r;
  in_item_t           s6_item_r;
  logic [LEN_W-1:0]   s6_len_r;
  logic [31:0]        s6_fs_r;
  d2_side_t           s7_r;
  logic [LEN_W-1:0]   s7_len_r;
  logic [62:0]        s7_pm_r [3];
  logic               s7_psgn_r [3];
  // s8..s10: force, impulse, velocity change
  d2_side_t    s8_r, s9_r;
  logic        s10_v_r;
  kind_t       s10_kind_r;
  logic [31:0] s8_fm_r  [3];
  logic        s8_fneg_r [3];
  logic [31:0] s9_imp_r [3];
  logic        s9_fneg_r [3];
  logic [46:0] s10_ma_r [3];
  logic [46:0] s10_mb_r [3];
  logic        s10_fneg_r [3];

  sq_side_t dl_sq_r [SQRT_STAGES];
  d1_side_t dl_d1_r [DIV_QW];
  d2_side_t dl_d2_r [DIV_QW+1];

  logic [LEN_W-1:0]  root;
  logic [DIV_QW-1:0] d1_q;
  logic              d1_ovf;
  logic [DIV_QW-1:0] d2_q [3];
  logic              d2_ovf [3];

  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  // Whole datapath advances unless a held result is stalled
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && q_status.valid;

  // ---- s1 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= q_status.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= q_head;
    end
  end

  // ---- s2 ----
  logic signed [31:0] s1_dp [3];
  logic signed [31:0] s1_dv [3];
  assign s1_dp[0] = s1_r.item.pos_diff_x;
  assign s1_dp[1] = s1_r.item.pos_diff_y;
  assign s1_dp[2] = s1_r.item.pos_diff_z;
  assign s1_dv[0] = s1_r.item.vel_diff_x;
  assign s1_dv[1] = s1_r.item.vel_diff_y;
  assign s1_dv[2] = s1_r.item.vel_diff_z;

  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_s2
      logic [31:0] dpm;
      assign dpm = abs32(s1_dp[a]);
      always_ff @(posedge clk) begin
        if (en) begin
          s2_sq_r[a] <= 64'(dpm) * 64'(dpm);
          s2_pr_r[a] <= s1_dv[a] * s1_dp[a];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s1_r;
    end
  end

  // ---- s3 ----
  logic signed [49:0] dot_sum;
  always_comb begin
    dot_sum = 50'($signed(trunc16(s2_pr_r[0]))) + 50'($signed(trunc16(s2_pr_r[1])))
            + 50'($signed(trunc16(s2_pr_r[2])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.v <= 1'b0;
    end else if (en) begin
      s3_r.v <= s2_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.kind <= s2_r.kind;
      s3_r.item <= s2_r.item;
      s3_r.dot  <= $signed(sat32(dot_sum));
      s3_sum_r  <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    end
  end

  // ---- length ----
  dsvu_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .s    (s3_sum_r),
    .root (root)
  );

  genvar t;
  generate
    for (t = 0; t < SQRT_STAGES; t++) begin : g_dl_sq
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dl_sq_r[t].v <= 1'b0;
        end else if (en) begin
          dl_sq_r[t].v <= (t == 0) ? s3_r.v : dl_sq_r[(t == 0) ? 0 : t-1].v;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (t == 0) begin
            dl_sq_r[t].kind <= s3_r.kind;
            dl_sq_r[t].item <= s3_r.item;
            dl_sq_r[t].dot  <= s3_r.dot;
          end else begin
            dl_sq_r[t].kind <= dl_sq_r[(t == 0) ? 0 : t-1].kind;
            dl_sq_r[t].item <= dl_sq_r[(t == 0) ? 0 : t-1].item;
            dl_sq_r[t].dot  <= dl_sq_r[(t == 0) ? 0 : t-1].dot;
          end
        end
      end
    end
  endgenerate

  // ---- s4 ----
  sq_side_t           sq_out;
  logic [LEN_W-1:0]   len_nxt;
  logic signed [33:0] ext_wide;
  logic [31:0]        dotm;
  assign sq_out = dl_sq_r[SQRT_STAGES-1];

  always_comb begin
    // Zero length clamps to the smallest positive step
    len_nxt  = (root == '0) ? LEN_W'(1) : root;
    ext_wide = $signed({2'b00, len_nxt}) - $signed({3'b000, sq_out.item.rest_length});
    dotm     = abs32(sq_out.dot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= sq_out.v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_kind_r <= sq_out.kind;
      s4_item_r <= sq_out.item;
      s4_len_r  <= len_nxt;
      s4_ext_r  <= (ext_wide > 34'sd2147483647) ? 32'sh7FFF_FFFF : ext_wide[31:0];
      s4_dm_r   <= 63'(sq_out.item.damping) * 63'(dotm);
      s4_dneg_r <= sq_out.dot[31];
    end
  end

  // ---- damping division ----
  dsvu_div u_div_damp (
    .clk (clk),
    .en  (en),
    .num (s4_dm_r),
    .den (s4_len_r),
    .quo (d1_q),
    .ovf (d1_ovf)
  );

  // ---- s5: Hooke term ----
  logic [31:0] extm;
  logic [62:0] hp;
  assign extm = abs32(s4_ext_r);
  assign hp   = 63'(s4_item_r.stiffness) * 63'(extm);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.v <= 1'b0;
    end else if (en) begin
      s5_r.v <= s4_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_r.kind  <= s4_kind_r;
      s5_r.item  <= s4_item_r;
      s5_r.len   <= s4_len_r;
      s5_r.hooke <= s4_ext_r[31] ? (48'd0 - {1'b0, hp[62:16]}) : {1'b0, hp[62:16]};
      s5_r.dneg  <= s4_dneg_r;
    end
  end

  generate
    for (t = 0; t < DIV_QW; t++) begin : g_dl_d1
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dl_d1_r[t].v <= 1'b0;
        end else if (en) begin
          dl_d1_r[t].v <= (t == 0) ? s5_r.v : dl_d1_r[(t == 0) ? 0 : t-1].v;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (t == 0) begin
            dl_d1_r[t].kind  <= s5_r.kind;
            dl_d1_r[t].item  <= s5_r.item;
            dl_d1_r[t].len   <= s5_r.len;
            dl_d1_r[t].hooke <= s5_r.hooke;
            dl_d1_r[t].dneg  <= s5_r.dneg;
          end else begin
            dl_d1_r[t].kind  <= dl_d1_r[(t == 0) ? 0 : t-1].kind;
            dl_d1_r[t].item  <= dl_d1_r[(t == 0) ? 0 : t-1].item;
            dl_d1_r[t].len   <= dl_d1_r[(t == 0) ? 0 : t-1].len;
            dl_d1_r[t].hooke <= dl_d1_r[(t == 0) ? 0 : t-1].hooke;
            dl_d1_r[t].dneg  <= dl_d1_r[(t == 0) ? 0 : t-1].dneg;
          end
        end
      end
    end
  endgenerate

  // ---- s6: scalar force ----
  d1_side_t           d1_out;
  logic [47:0]        dmag;
  logic [48:0]        damp;
  logic signed [49:0] fs_sum;
  assign d1_out = dl_d1_r[DIV_QW-1];

  always_comb begin
    // Past 2^47 the damping term alone decides saturation
    dmag   = d1_ovf ? 48'h8000_0000_0000 : {1'b0, d1_q};
    damp   = d1_out.dneg ? (49'd0 - {1'b0, dmag}) : {1'b0, dmag};
    fs_sum = 50'($signed(d1_out.hooke)) + 50'($signed(damp));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= d1_out.v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_kind_r <= d1_out.kind;
      s6_item_r <= d1_out.item;
      s6_len_r  <= d1_out.len;
      s6_fs_r   <= sat32(fs_sum);
    end
  end

  // ---- s7: force times direction ----
  logic [31:0] s6_dp [3];
  assign s6_dp[0] = s6_item_r.pos_diff_x;
  assign s6_dp[1] = s6_item_r.pos_diff_y;
  assign s6_dp[2] = s6_item_r.pos_diff_z;

  logic [31:0] fsm;
  assign fsm = abs32(s6_fs_r);

  generate
    for (a = 0; a < 3; a++) begin : g_s7
      logic [63:0] pm;
      assign pm = 64'(fsm) * 64'(abs32(s6_dp[a]));
      always_ff @(posedge clk) begin
        if (en) begin
          s7_pm_r[a]   <= pm[62:0];
          s7_psgn_r[a] <= s6_fs_r[31] ^ s6_dp[a][31];
        end
      end

      dsvu_div u_div_dir (
        .clk (clk),
        .en  (en),
        .num (s7_pm_r[a]),
        .den (s7_len_r),
        .quo (d2_q[a]),
        .ovf (d2_ovf[a])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_r.v <= 1'b0;
    end else if (en) begin
      s7_r.v <= s6_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_r.kind <= s6_kind_r;
      s7_r.ima  <= s6_item_r.inv_mass_a;
      s7_r.imb  <= s6_item_r.inv_mass_b;
      s7_len_r  <= s6_len_r;
    end
  end

  // Sign of each product rides alongside the dividers
  logic dl_psgn_r [DIV_QW+1][3];

  generate
    for (t = 0; t <= DIV_QW; t++) begin : g_dl_d2
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dl_d2_r[t].v <= 1'b0;
        end else if (en) begin
          dl_d2_r[t].v <= (t == 0) ? s7_r.v : dl_d2_r[(t == 0) ? 0 : t-1].v;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (t == 0) begin
            dl_d2_r[t].kind <= s7_r.kind;
            dl_d2_r[t].ima  <= s7_r.ima;
            dl_d2_r[t].imb  <= s7_r.imb;
            for (int i = 0; i < 3; i++) begin
              dl_psgn_r[t][i] <= s7_psgn_r[i];
            end
          end else begin
            dl_d2_r[t].kind <= dl_d2_r[(t == 0) ? 0 : t-1].kind;
            dl_d2_r[t].ima  <= dl_d2_r[(t == 0) ? 0 : t-1].ima;
            dl_d2_r[t].imb  <= dl_d2_r[(t == 0) ? 0 : t-1].imb;
            for (int i = 0; i < 3; i++) begin
              dl_psgn_r[t][i] <= dl_psgn_r[(t == 0) ? 0 : t-1][i];
            end
          end
        end
      end
    end
  endgenerate

  // ---- s8..s10 per axis ----
  generate
    for (a = 0; a < 3; a++) begin : g_tail
      logic [31:0] qm;
      logic        fneg;
      logic [48:0] ip;
      logic [62:0] pa, pb;

      always_comb begin
        // Quotient above 2^31 saturates either way
        qm   = (d2_ovf[a] || (d2_q[a] > 47'h0_8000_0000)) ? 32'h8000_0000
             : d2_q[a][31:0];
        fneg = !dl_psgn_r[DIV_QW][a];
        ip   = 49'(s8_fm_r[a]) * 49'(time_step);
        pa   = 63'(s9_imp_r[a]) * 63'(s9_r.ima);
        pb   = 63'(s9_imp_r[a]) * 63'(s9_r.imb);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          s8_fm_r[a]    <= (!fneg && (qm > 32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qm;
          s8_fneg_r[a]  <= fneg;
          s9_imp_r[a]   <= ip[47:16];
          s9_fneg_r[a]  <= s8_fneg_r[a];
          s10_ma_r[a]   <= pa[62:16];
          s10_mb_r[a]   <= pb[62:16];
          s10_fneg_r[a] <= s9_fneg_r[a];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_r.v  <= 1'b0;
      s9_r.v  <= 1'b0;
      s10_v_r <= 1'b0;
    end else if (en) begin
      s8_r.v  <= dl_d2_r[DIV_QW].v;
      s9_r.v  <= s8_r.v;
      s10_v_r <= s9_r.v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_r.kind  <= dl_d2_r[DIV_QW].kind;
      s8_r.ima   <= dl_d2_r[DIV_QW].ima;
      s8_r.imb   <= dl_d2_r[DIV_QW].imb;
      s9_r.kind  <= s8_r.kind;
      s9_r.ima   <= s8_r.ima;
      s9_r.imb   <= s8_r.imb;
      s10_kind_r <= s9_r.kind;
    end
  end

  // ---- output register ----
  always_comb begin
    if (s10_kind_r == KIND_PINNED) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt.dvel_a_x = sat_mag(s10_fneg_r[0], s10_ma_r[0]);
      out_data_nxt.dvel_a_y = sat_mag(s10_fneg_r[1], s10_ma_r[1]);
      out_data_nxt.dvel_a_z = sat_mag(s10_fneg_r[2], s10_ma_r[2]);
      out_data_nxt.dvel_b_x = sat_mag(!s10_fneg_r[0], s10_mb_r[0]);
      out_data_nxt.dvel_b_y = sat_mag(!s10_fneg_r[1], s10_mb_r[1]);
      out_data_nxt.dvel_b_z = sat_mag(!s10_fneg_r[2], s10_mb_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s10_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
